// ----- rtl/grid_dfs_reachability_unit_macros.svh -----
// Assertion helpers for the grid search RTL.
`ifndef GRID_DFS_REACHABILITY_UNIT_MACROS_SVH
`define GRID_DFS_REACHABILITY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define GDR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define GDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GDR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define GDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/gdr_pkg.sv -----
`default_nettype none

package gdr_pkg;

   localparam int DEF_GRID_ROWS = 16;
   localparam int DEF_GRID_COLS = 16;

   // Request coordinate width and a width that holds any grid limit.
   localparam int COORD_W = 4;
   localparam int LIM_W   = 7;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   localparam logic [1:0] KIND_OPEN = 2'd0;
   localparam logic [1:0] KIND_WALL = 2'd1;
   localparam logic [1:0] KIND_GOAL = 2'd2;

   // Neighbor order: west, south, east, north.
   localparam logic [1:0] DIR_WEST  = 2'd0;
   localparam logic [1:0] DIR_SOUTH = 2'd1;
   localparam logic [1:0] DIR_EAST  = 2'd2;
   localparam logic [1:0] DIR_NORTH = 2'd3;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SEED,
      ST_POP,
      ST_POP_WAIT,
      ST_GOAL_CHK,
      ST_NB_RD,
      ST_NB_EVAL,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/gdr_nbr_unit.sv -----
`default_nettype none

// Shared neighbor step: one add on the selected coordinate plus a bound check.
module gdr_nbr_unit #(
   parameter int GRID_ROWS = gdr_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = gdr_pkg::DEF_GRID_COLS,
   localparam int RW = $clog2(GRID_ROWS),
   localparam int CW = $clog2(GRID_COLS)
) (
   input  logic [RW-1:0] cur_row,
   input  logic [CW-1:0] cur_col,
   input  logic [1:0]    dir,
   output logic [RW-1:0] nb_row,
   output logic [CW-1:0] nb_col,
   output logic          nb_ok
);

   localparam int PW = ((RW > CW) ? RW : CW) + 1;

   logic          use_col;
   logic          inc;
   logic [PW-1:0] sel;
   logic [PW-1:0] lim;
   logic [PW-1:0] step;
   logic [PW-1:0] sum;

   assign use_col = (dir == gdr_pkg::DIR_WEST) || (dir == gdr_pkg::DIR_EAST);
   assign inc     = (dir == gdr_pkg::DIR_SOUTH) || (dir == gdr_pkg::DIR_EAST);
   assign sel     = use_col ? PW'(cur_col) : PW'(cur_row);
   assign lim     = use_col ? PW'(GRID_COLS) : PW'(GRID_ROWS);
   assign step    = inc ? PW'(1) : {PW{1'b1}};
   assign sum     = sel + step;

   assign nb_ok  = inc ? (sum < lim) : (sel != '0);
   assign nb_row = use_col ? cur_row : sum[RW-1:0];
   assign nb_col = use_col ? sum[CW-1:0] : cur_col;

endmodule

`default_nettype wire

// ----- rtl/grid_dfs_reachability_unit.sv -----
// A write request is stored in the idle state and never raises busy; a search first
// clears the visited marks, then pops cells and reads up to four neighbors of each.
// One request at a time: busy stays high through the result strobe, which the
// receiver cannot stall. After synchronous reset the block sweeps the cell memory
// to open and the marks to clear, one entry per cycle, with busy high; the neighbor
// step unit and the memories' single read and write ports set the pace.
`default_nettype none

`include "grid_dfs_reachability_unit_macros.svh"

module grid_dfs_reachability_unit #(
   parameter int GRID_ROWS = gdr_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = gdr_pkg::DEF_GRID_COLS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_type,
   input  logic [gdr_pkg::COORD_W-1:0] req_row,
   input  logic [gdr_pkg::COORD_W-1:0] req_col,
   input  logic [1:0]                  req_cell_kind,
   output logic                        rsp_valid,
   output logic                        rsp_reachable
);

   localparam int RW    = $clog2(GRID_ROWS);
   localparam int CW    = $clog2(GRID_COLS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;
   localparam int CNT_W = AW + 1;
   localparam int LW    = gdr_pkg::LIM_W;
   localparam int PADW  = LW - gdr_pkg::COORD_W;

   gdr_pkg::state_type state_ff, state_in;

   // Cell kinds, visited marks and the push-down stack, one read and one write port each.
   logic [1:0]    cell_mem [DEPTH];
   logic          vis_mem  [DEPTH];
   logic [AW-1:0] stk_mem  [DEPTH];

   logic          cell_we, vis_we, stk_we;
   logic [AW-1:0] cell_waddr, cell_raddr, vis_waddr, vis_raddr, stk_waddr, stk_raddr;
   logic [1:0]    cell_wdata, cell_rd_ff;
   logic          vis_wdata, vis_rd_ff;
   logic [AW-1:0] stk_wdata, stk_rd_ff;

   logic [AW-1:0]               sweep_ff, sweep_in;
   logic [CNT_W-1:0]            stk_cnt_ff, stk_cnt_in;
   logic [CNT_W-1:0]            stk_dec;
   logic [AW-1:0]               cur_ff, cur_in;
   logic [1:0]                  dir_ff, dir_in;
   logic                        found_ff, found_in;
   logic [gdr_pkg::COORD_W-1:0] start_row_ff, start_row_in, start_col_ff, start_col_in;

   logic          accept;
   logic          acc_search, acc_write;
   logic          req_ok, start_ok, push_ok, sweep_last;
   logic [AW-1:0] req_addr, start_addr, nb_addr;
   logic [RW-1:0] nb_row;
   logic [CW-1:0] nb_col;
   logic          nb_ok;

   assign accept     = start && !busy;
   assign acc_search = accept && (req_type == gdr_pkg::REQ_SEARCH);
   assign acc_write  = accept && (req_type == gdr_pkg::REQ_WRITE);
   assign busy       = (state_ff != gdr_pkg::ST_IDLE);
   assign rsp_valid  = (state_ff == gdr_pkg::ST_DONE);
   assign rsp_reachable = found_ff;

   // Bound checks on the 4-bit request coordinates against the grid size.
   assign req_ok   = ({{PADW{1'b0}}, req_row} < LW'(GRID_ROWS)) &&
                     ({{PADW{1'b0}}, req_col} < LW'(GRID_COLS));
   assign start_ok = ({{PADW{1'b0}}, start_row_ff} < LW'(GRID_ROWS)) &&
                     ({{PADW{1'b0}}, start_col_ff} < LW'(GRID_COLS));
   assign req_addr   = {RW'(req_row), CW'(req_col)};
   assign start_addr = {RW'(start_row_ff), CW'(start_col_ff)};

   assign stk_dec    = stk_cnt_ff - CNT_W'(1);
   assign sweep_last = &sweep_ff;
   assign nb_addr    = {nb_row, nb_col};
   // Walls and already-marked neighbors are never pushed.
   assign push_ok    = (cell_rd_ff != gdr_pkg::KIND_WALL) && !vis_rd_ff;

   gdr_nbr_unit #(
      .GRID_ROWS(GRID_ROWS),
      .GRID_COLS(GRID_COLS)
   ) u_nbr (
      .cur_row(cur_ff[AW-1:CW]),
      .cur_col(cur_ff[CW-1:0]),
      .dir    (dir_ff),
      .nb_row (nb_row),
      .nb_col (nb_col),
      .nb_ok  (nb_ok)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gdr_pkg::ST_INIT: begin
            if (sweep_last) state_in = gdr_pkg::ST_IDLE;
         end
         gdr_pkg::ST_IDLE: begin
            if (acc_search) state_in = gdr_pkg::ST_CLEAR;
         end
         gdr_pkg::ST_CLEAR: begin
            if (sweep_last) state_in = gdr_pkg::ST_SEED;
         end
         gdr_pkg::ST_SEED: begin
            // A start outside the grid ends at once with no goal.
            state_in = start_ok ? gdr_pkg::ST_POP : gdr_pkg::ST_DONE;
         end
         gdr_pkg::ST_POP: begin
            state_in = (stk_cnt_ff == '0) ? gdr_pkg::ST_DONE : gdr_pkg::ST_POP_WAIT;
         end
         gdr_pkg::ST_POP_WAIT: begin
            state_in = gdr_pkg::ST_GOAL_CHK;
         end
         gdr_pkg::ST_GOAL_CHK: begin
            state_in = (cell_rd_ff == gdr_pkg::KIND_GOAL) ? gdr_pkg::ST_DONE
                                                         : gdr_pkg::ST_NB_RD;
         end
         gdr_pkg::ST_NB_RD: begin
            if (nb_ok) state_in = gdr_pkg::ST_NB_EVAL;
            else if (dir_ff == gdr_pkg::DIR_NORTH) state_in = gdr_pkg::ST_POP;
         end
         gdr_pkg::ST_NB_EVAL: begin
            state_in = (dir_ff == gdr_pkg::DIR_NORTH) ? gdr_pkg::ST_POP : gdr_pkg::ST_NB_RD;
         end
         gdr_pkg::ST_DONE: begin
            state_in = gdr_pkg::ST_IDLE;
         end
         default: begin
            state_in = gdr_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory controls and datapath next values.
   always_comb begin
      cell_we      = 1'b0;
      cell_waddr   = sweep_ff;
      cell_wdata   = gdr_pkg::KIND_OPEN;
      cell_raddr   = nb_addr;
      vis_we       = 1'b0;
      vis_waddr    = sweep_ff;
      vis_wdata    = 1'b0;
      vis_raddr    = nb_addr;
      stk_we       = 1'b0;
      stk_waddr    = stk_cnt_ff[AW-1:0];
      stk_wdata    = nb_addr;
      stk_raddr    = stk_dec[AW-1:0];
      sweep_in     = sweep_ff;
      stk_cnt_in   = stk_cnt_ff;
      cur_in       = cur_ff;
      dir_in       = dir_ff;
      found_in     = found_ff;
      start_row_in = start_row_ff;
      start_col_in = start_col_ff;
      case (state_ff)
         gdr_pkg::ST_INIT: begin
            // Sweep every cell to open and every mark to clear.
            cell_we  = 1'b1;
            vis_we   = 1'b1;
            sweep_in = sweep_ff + AW'(1);
         end
         gdr_pkg::ST_IDLE: begin
            if (acc_write && req_ok) begin
               // Store the cell; the unused kind code reads back as open.
               cell_we    = 1'b1;
               cell_waddr = req_addr;
               cell_wdata = (req_cell_kind == gdr_pkg::KIND_WALL ||
                             req_cell_kind == gdr_pkg::KIND_GOAL) ? req_cell_kind
                                                                  : gdr_pkg::KIND_OPEN;
            end
            if (acc_search) begin
               start_row_in = req_row;
               start_col_in = req_col;
            end
         end
         gdr_pkg::ST_CLEAR: begin
            vis_we   = 1'b1;
            sweep_in = sweep_ff + AW'(1);
         end
         gdr_pkg::ST_SEED: begin
            stk_cnt_in = '0;
            found_in   = 1'b0;
            if (start_ok) begin
               // Push the start cell without a wall check.
               vis_we     = 1'b1;
               vis_waddr  = start_addr;
               vis_wdata  = 1'b1;
               stk_we     = 1'b1;
               stk_waddr  = '0;
               stk_wdata  = start_addr;
               stk_cnt_in = CNT_W'(1);
            end
         end
         gdr_pkg::ST_POP: begin
            if (stk_cnt_ff != '0) stk_cnt_in = stk_dec;
         end
         gdr_pkg::ST_POP_WAIT: begin
            cur_in     = stk_rd_ff;
            cell_raddr = stk_rd_ff;
            dir_in     = gdr_pkg::DIR_WEST;
         end
         gdr_pkg::ST_GOAL_CHK: begin
            if (cell_rd_ff == gdr_pkg::KIND_GOAL) found_in = 1'b1;
         end
         gdr_pkg::ST_NB_RD: begin
            // Skip a neighbor off the grid edge.
            if (!nb_ok) dir_in = dir_ff + 2'd1;
         end
         gdr_pkg::ST_NB_EVAL: begin
            if (push_ok) begin
               vis_we     = 1'b1;
               vis_waddr  = nb_addr;
               vis_wdata  = 1'b1;
               stk_we     = 1'b1;
               stk_cnt_in = stk_cnt_ff + CNT_W'(1);
            end
            dir_in = dir_ff + 2'd1;
         end
         gdr_pkg::ST_DONE: begin
            found_in = found_ff;
         end
         default: begin
            found_in = found_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gdr_pkg::ST_INIT;
         sweep_ff   <= '0;
         stk_cnt_ff <= '0;
         dir_ff     <= gdr_pkg::DIR_WEST;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         stk_cnt_ff <= stk_cnt_in;
         dir_ff     <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      found_ff     <= found_in;
      start_row_ff <= start_row_in;
      start_col_ff <= start_col_in;
   end

   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
      vis_rd_ff <= vis_mem[vis_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   // Each cell is pushed at most once, so the stack never overfills.
   `GDR_ASSERT_IMPL(a_stack_bound, clock, reset, 1'b1, stk_cnt_ff <= CNT_W'(DEPTH), "stack over")
   `GDR_ASSERT_NEXT(a_search_busy, clock, reset, acc_search, busy && !rsp_valid, "no search")
   `GDR_ASSERT_NEXT(a_write_quiet, clock, reset, acc_write, !rsp_valid && !busy, "write result")
   `GDR_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid && !busy, "long strobe")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;

   localparam int ROWS  = gdr_pkg::DEF_GRID_ROWS;
   localparam int COLS  = gdr_pkg::DEF_GRID_COLS;
   localparam int CELLS = ROWS * COLS;
   localparam int CW    = gdr_pkg::COORD_W;

   // A write with this kind must land as an open cell.
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // Neighbor steps in search order: west, south, east, north.
   localparam int STEP_ROW [4] = '{0, 1, 0, -1};
   localparam int STEP_COL [4] = '{-1, 0, 1, 0};

   // Cycles with no request taken and no result seen before giving up.
   localparam int QUIET_LIMIT = 20000;
   localparam int RANDOM_REQS = 400;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_type;
   logic [CW-1:0]        req_row;
   logic [CW-1:0]        req_col;
   logic [1:0]           req_cell_kind;
   logic                 rsp_valid;
   logic                 rsp_reachable;

   grid_dfs_reachability_unit uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_cell_kind (req_cell_kind),
      .rsp_valid     (rsp_valid),
      .rsp_reachable (rsp_reachable)
   );

   // One row of the directed table; known_reach marks rows whose answer is
   // typed in by hand instead of taken from the search model.
   typedef struct {
      logic          kind_of_req;
      logic [CW-1:0] row;
      logic [CW-1:0] col;
      logic [1:0]    kind_code;
      bit            known_reach;
      logic          reach;
   } grid_req_type;

   // Shadow of the block: cell kinds, visited marks and the search stack.
   logic [1:0] grid_kind [CELLS];
   bit         visited   [CELLS];
   int         dfs_stack [CELLS];

   // Answers still owed by the block, oldest first.
   logic         pending_reach [$];
   grid_req_type directed_reqs [$];

   // Typed answer for the request now on the ports, if any.
   bit         typed_valid;
   logic       typed_reach;

   int         idle_pct;
   int         quiet_cycles;
   bit         failed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Store one cell the way the block does: out-of-grid writes drop, an
   // unknown kind lands as open.
   function automatic void store_cell(input int r, input int c, input logic [1:0] k);
      if (r < ROWS && c < COLS)
         grid_kind[r * COLS + c] = (k > gdr_pkg::KIND_GOAL) ? gdr_pkg::KIND_OPEN : k;
   endfunction

   // Depth-first search from (r0, c0): clear marks, push the start unchecked,
   // mark on push, stop at the first goal popped.
   function automatic logic search_goal(input int r0, input int c0);
      int   i;
      int   top;
      int   cur;
      int   nr;
      int   nc;
      int   nb;
      logic found;
      for (i = 0; i < CELLS; i++)
         visited[i] = 1'b0;
      found = 1'b0;
      top = 0;
      if (r0 >= ROWS || c0 >= COLS)
         return 1'b0;
      cur = r0 * COLS + c0;
      visited[cur] = 1'b1;
      dfs_stack[0] = cur;
      top = 1;
      while (top > 0 && !found) begin
         top--;
         cur = dfs_stack[top];
         if (grid_kind[cur] == gdr_pkg::KIND_GOAL) begin
            found = 1'b1;
         end else begin
            for (i = 0; i < 4; i++) begin
               nr = cur / COLS + STEP_ROW[i];
               nc = cur % COLS + STEP_COL[i];
               // Skip neighbors off any edge of the grid.
               if (nr >= 0 && nc >= 0 && nr < ROWS && nc < COLS) begin
                  nb = nr * COLS + nc;
                  if (grid_kind[nb] != gdr_pkg::KIND_WALL && !visited[nb] &&
                      top < CELLS) begin
                     visited[nb] = 1'b1;
                     dfs_stack[top] = nb;
                     top++;
                  end
               end
            end
         end
      end
      return found;
   endfunction

   task automatic add_row(input logic t, input int r, input int c, input logic [1:0] k,
                          input bit known, input logic reach);
      grid_req_type item;
      item.kind_of_req = t;
      item.row         = r[CW-1:0];
      item.col         = c[CW-1:0];
      item.kind_code   = k;
      item.known_reach = known;
      item.reach       = reach;
      directed_reqs.push_back(item);
   endtask

   // Present one request from a falling edge and hold it until taken. The
   // sender may first idle with junk on the request ports.
   task automatic send_request(input grid_req_type item);
      int gap;
      @(negedge clock);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 8);
         start         <= 1'b0;
         req_type      <= 1'($urandom);
         req_row       <= CW'($urandom);
         req_col       <= CW'($urandom);
         req_cell_kind <= 2'($urandom);
         repeat (gap) @(negedge clock);
      end
      typed_valid    = item.known_reach;
      typed_reach    = item.reach;
      req_type      <= item.kind_of_req;
      req_row       <= item.row;
      req_col       <= item.col;
      req_cell_kind <= item.kind_code;
      start         <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Random request. Most are writes that build a maze about half walls with
   // a sprinkling of goals, so searches end both ways and stay short once the
   // walls break the grid into pockets.
   function automatic grid_req_type random_request();
      grid_req_type item;
      int           roll;
      item.known_reach = 1'b0;
      item.reach       = 1'b0;
      item.row         = CW'($urandom);
      item.col         = CW'($urandom);
      item.kind_code   = 2'($urandom);
      if ($urandom_range(99) < 35) begin
         item.kind_of_req = gdr_pkg::REQ_SEARCH;
      end else begin
         item.kind_of_req = gdr_pkg::REQ_WRITE;
         roll = $urandom_range(99);
         if (roll < 48)      item.kind_code = gdr_pkg::KIND_WALL;
         else if (roll < 78) item.kind_code = gdr_pkg::KIND_OPEN;
         else if (roll < 90) item.kind_code = gdr_pkg::KIND_GOAL;
         else                item.kind_code = KIND_UNKNOWN;
      end
      return item;
   endfunction

   // Check results against the oldest owed answer, then take in any request
   // accepted at this edge.
   always @(posedge clock) begin
      logic want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_reach.size() == 0) begin
               $error("reachable: no result expected, got %0b", rsp_reachable);
               failed = 1'b1;
            end else begin
               want = pending_reach.pop_front();
               if (rsp_reachable !== want) begin
                  $error("reachable: expected %0b, got %0b", want, rsp_reachable);
                  failed = 1'b1;
               end
            end
         end
         if (start && busy === 1'b0) begin
            if (req_type == gdr_pkg::REQ_WRITE) begin
               store_cell(int'(req_row), int'(req_col), req_cell_kind);
            end else begin
               want = search_goal(int'(req_row), int'(req_col));
               if (typed_valid)
                  want = typed_reach;
               pending_reach.push_back(want);
            end
         end
      end
   end

   // Watchdog: any taken request or any result counts as progress.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && busy === 1'b0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int           phase;
      int           n;
      grid_req_type item;

      failed        = 1'b0;
      typed_valid   = 1'b0;
      typed_reach   = 1'b0;
      idle_pct      = 0;
      quiet_cycles  = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = gdr_pkg::REQ_WRITE;
      req_row       = '0;
      req_col       = '0;
      req_cell_kind = gdr_pkg::KIND_OPEN;
      for (n = 0; n < CELLS; n++) begin
         grid_kind[n] = gdr_pkg::KIND_OPEN;
         visited[n]   = 1'b0;
         dfs_stack[n] = 0;
      end

      // Directed table: corners, both coordinate extremes, every cell kind,
      // starts on a goal and on a wall, enclosed goals.
      // Empty grid after reset: nothing to find, whole grid explored.
      add_row(gdr_pkg::REQ_SEARCH, 0, 0, gdr_pkg::KIND_OPEN, 1'b1, 1'b0);
      add_row(gdr_pkg::REQ_SEARCH, 15, 15, KIND_UNKNOWN, 1'b1, 1'b0);
      add_row(gdr_pkg::REQ_WRITE, 15, 15, gdr_pkg::KIND_GOAL, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_SEARCH, 0, 0, gdr_pkg::KIND_OPEN, 1'b1, 1'b1);
      // Start right on the goal.
      add_row(gdr_pkg::REQ_SEARCH, 15, 15, gdr_pkg::KIND_WALL, 1'b1, 1'b1);
      // Wall the goal into its corner.
      add_row(gdr_pkg::REQ_WRITE, 15, 14, gdr_pkg::KIND_WALL, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_WRITE, 14, 15, gdr_pkg::KIND_WALL, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_SEARCH, 0, 0, gdr_pkg::KIND_GOAL, 1'b1, 1'b0);
      // Start on a wall next to the goal: the start is pushed unchecked.
      add_row(gdr_pkg::REQ_SEARCH, 15, 14, gdr_pkg::KIND_OPEN, 1'b0, 1'b0);
      // Unknown kind overwrites the goal as open: no goal left.
      add_row(gdr_pkg::REQ_WRITE, 15, 15, KIND_UNKNOWN, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_SEARCH, 15, 14, gdr_pkg::KIND_OPEN, 1'b1, 1'b0);
      add_row(gdr_pkg::REQ_WRITE, 0, 0, gdr_pkg::KIND_GOAL, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_SEARCH, 0, 15, KIND_UNKNOWN, 1'b1, 1'b1);
      add_row(gdr_pkg::REQ_WRITE, 0, 1, gdr_pkg::KIND_WALL, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_WRITE, 1, 0, gdr_pkg::KIND_WALL, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_SEARCH, 0, 15, gdr_pkg::KIND_OPEN, 1'b1, 1'b0);
      add_row(gdr_pkg::REQ_SEARCH, 0, 1, gdr_pkg::KIND_OPEN, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_WRITE, 10, 5, gdr_pkg::KIND_GOAL, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_SEARCH, 5, 10, gdr_pkg::KIND_GOAL, 1'b1, 1'b1);
      // Put the grid back to all open for the random part.
      add_row(gdr_pkg::REQ_WRITE, 10, 5, gdr_pkg::KIND_OPEN, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_WRITE, 0, 0, gdr_pkg::KIND_OPEN, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_WRITE, 0, 1, gdr_pkg::KIND_OPEN, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_WRITE, 1, 0, gdr_pkg::KIND_OPEN, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_WRITE, 15, 14, gdr_pkg::KIND_OPEN, 1'b0, 1'b0);
      add_row(gdr_pkg::REQ_WRITE, 14, 15, gdr_pkg::KIND_OPEN, 1'b0, 1'b0);

      // After reset the block sweeps its cell memory with busy high, which the
      // first request simply waits out.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_reqs[i])
         send_request(directed_reqs[i]);

      // Random phases: back to back, sender idle often, sender idle rarely.
      // Drop start and drain every owed answer between phases so the sender
      // also pauses on an idle block.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
            end
            1: begin
               idle_pct = 46;
            end
            default: begin
               idle_pct = 11;
            end
         endcase
         for (n = 0; n < RANDOM_REQS / 3; n++) begin
            item = random_request();
            send_request(item);
         end
         @(negedge clock);
         start <= 1'b0;
         while (pending_reach.size() != 0)
            @(posedge clock);
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_reach.size() != 0)
         @(posedge clock);
      // Let any trailing write settle before judging.
      repeat (16) @(posedge clock);

      if (!failed && pending_reach.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
